@@ hdl/bdst_pkg.sv @@
package bdst_pkg;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  typedef enum logic [CFG_AW-1:0] {
    REG_BLOCKS_PER_DISK     = 3'd0,
    REG_PARTITION_START     = 3'd1,
    REG_LAST_ALLOWED_SECTOR = 3'd2,
    REG_TRACK_SECTORS       = 3'd3,
    REG_CYLINDER_SECTORS    = 3'd4,
    REG_SECTOR_BIAS         = 3'd5,
    REG_GEOMETRY_MODE       = 3'd6,
    REG_BAD_COUNT           = 3'd7
  } cfg_reg_t;

  localparam logic CMD_LOAD      = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  typedef struct packed {
    logic [7:0]  logical_disk;
    logic [15:0] record_number;
  } xlate_req_t;

  typedef struct packed {
    logic        command;
    logic [7:0]  logical_disk;
    logic [15:0] record_number;
    logic [7:0]  table_index;
    logic [31:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] linear_sector;
    logic [40:0] byte_offset;
    logic [31:0] cylinder;
    logic [7:0]  head;
    logic [8:0]  sector_in_track;
    logic        status;
  } out_item_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_MUL,
    BE_WALK,
    BE_WAIT,
    BE_DIV_CYL,
    BE_DIV_HEAD,
    BE_OUT
  } be_state_t;

endpackage

@@ hdl/bdst_if.sv @@
interface bdst_in_if import bdst_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bdst_out_if import bdst_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/bdst_ram.sv @@
module bdst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/bdst_front.sv @@
// accepts beats, writes table loads, queues translate requests (depth 2)
module bdst_front import bdst_pkg::*; #(
  parameter int unsigned MAX_BAD_BLOCKS = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  in_item_t                          in_data,
  output logic                              tbl_we,
  output logic [$clog2(MAX_BAD_BLOCKS)-1:0] tbl_waddr,
  output logic [31:0]                       tbl_wdata,
  output logic                              q_valid,
  output xlate_req_t                        q_data,
  input  logic                              q_pop,
  input  logic                              tbl_busy
);
  localparam int unsigned IW = $clog2(MAX_BAD_BLOCKS);

  xlate_req_t q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       acc, push;

  // a load waits until no earlier translate still needs the table
  assign in_ready = (cnt_r != 2'd2) &&
                    ((in_data.command == CMD_TRANSLATE) ||
                     ((cnt_r == 2'd0) && !tbl_busy));
  assign acc      = in_valid && in_ready;
  assign push     = acc && (in_data.command == CMD_TRANSLATE);

  assign tbl_we    = acc && (in_data.command == CMD_LOAD)
                     && ({24'd0, in_data.table_index} < 32'(MAX_BAD_BLOCKS));
  assign tbl_waddr = IW'({24'd0, in_data.table_index});
  assign tbl_wdata = in_data.table_value;

  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{logical_disk: in_data.logical_disk,
                     record_number: in_data.record_number};
    end
  end
endmodule

@@ hdl/bdst_back.sv @@
// multiply, bad-block walk, two restoring divides in geometry mode if in range, output register
module bdst_back import bdst_pkg::*; #(
  parameter int unsigned MAX_BAD_BLOCKS = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  xlate_req_t                        q_data,
  output logic                              q_pop,
  output logic                              tbl_busy,
  output logic [$clog2(MAX_BAD_BLOCKS)-1:0] tbl_raddr,
  input  logic [31:0]                       tbl_rdata,
  input  logic [23:0]                       blocks_per_disk,
  input  logic [31:0]                       partition_start,
  input  logic [31:0]                       last_allowed_sector,
  input  logic [5:0]                        track_sectors,
  input  logic [13:0]                       cylinder_sectors,
  input  logic [7:0]                        sector_bias,
  input  logic                              geometry_mode,
  input  logic [8:0]                        bad_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output out_item_t                         out_data
);
  localparam int unsigned IW = $clog2(MAX_BAD_BLOCKS);
  localparam int unsigned NW = $clog2(MAX_BAD_BLOCKS + 1);

  be_state_t   st_r, st_nxt;
  xlate_req_t  req_r, req_nxt;
  logic [31:0] s_r, s_nxt;
  logic [NW-1:0] i_r, i_nxt, n_lim;
  logic        first_r, first_nxt;
  logic [31:0] quo_r, quo_nxt, rem_r, rem_nxt;
  logic [5:0]  bit_r, bit_nxt;
  logic [31:0] cyl_r, cyl_nxt;
  logic        ovf_r, ovf_nxt;
  out_item_t   res_r, res_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] divisor, trial_rem;
  logic [32:0] trial;
  logic [13:0] cs;
  logic [5:0]  ts;
  logic [9:0]  sec_sum;

  assign n_lim = (32'(bad_count) > 32'(MAX_BAD_BLOCKS)) ?
                 NW'(MAX_BAD_BLOCKS) : NW'(bad_count);
  assign tbl_raddr = i_r[IW-1:0];
  // table is read from the multiply through the walk
  assign tbl_busy  = (st_r == BE_MUL) || (st_r == BE_WALK);
  assign cs = (cylinder_sectors == 14'd0) ? 14'd1 : cylinder_sectors;
  assign ts = (track_sectors == 6'd0) ? 6'd1 : track_sectors;
  assign divisor   = (st_r == BE_DIV_CYL) ? {18'd0, cs} : {26'd0, ts};
  assign trial_rem = {rem_r[30:0], quo_r[31]};
  assign trial     = {1'b0, trial_rem} - {1'b0, divisor};
  assign out_valid = ov_r;
  assign out_data  = res_r;

  always_comb begin
    st_nxt = st_r; req_nxt = req_r; s_nxt = s_r; i_nxt = i_r;
    first_nxt = first_r; quo_nxt = quo_r; rem_nxt = rem_r; bit_nxt = bit_r;
    cyl_nxt = cyl_r; ovf_nxt = ovf_r; res_nxt = res_r; ov_nxt = ov_r;
    q_pop = 1'b0;
    sec_sum = '0;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      BE_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          req_nxt = q_data;
          st_nxt = BE_MUL;
        end
      end
      BE_MUL: begin
        s_nxt = 32'({24'd0, req_r.logical_disk} * {8'd0, blocks_per_disk})
                + {16'd0, req_r.record_number};
        i_nxt = '0;
        first_nxt = 1'b1;
        st_nxt = BE_WALK;
      end
      BE_WALK: begin
        // rdata of entry i_r-1 is valid when not first
        if (!first_r && (s_r >= tbl_rdata)) begin
          s_nxt = s_r + 32'd1;
        end
        first_nxt = 1'b0;
        if (i_r == n_lim) begin
          st_nxt = BE_WAIT;
        end else begin
          i_nxt = i_r + NW'(1);
        end
        if (first_r && (n_lim == '0)) begin
          st_nxt = BE_WAIT;
        end
      end
      BE_WAIT: begin
        s_nxt = s_r + partition_start;
        ovf_nxt = 1'b0;
        st_nxt = BE_OUT;
        if (geometry_mode) begin
          ovf_nxt = (s_r + partition_start) > last_allowed_sector;
          if (!((s_r + partition_start) > last_allowed_sector)) begin
            quo_nxt = s_r + partition_start;
            rem_nxt = '0;
            bit_nxt = 6'd32;
            st_nxt = BE_DIV_CYL;
          end
        end
      end
      BE_DIV_CYL, BE_DIV_HEAD: begin
        // one quotient bit per cycle
        quo_nxt = {quo_r[30:0], ~trial[32]};
        rem_nxt = trial[32] ? trial_rem : trial[31:0];
        bit_nxt = bit_r - 6'd1;
        if (bit_r == 6'd1) begin
          if (st_r == BE_DIV_CYL) begin
            cyl_nxt = {quo_r[30:0], ~trial[32]};
            quo_nxt = trial[32] ? trial_rem : trial[31:0];
            rem_nxt = '0;
            bit_nxt = 6'd32;
            st_nxt = BE_DIV_HEAD;
          end else begin
            st_nxt = BE_OUT;
          end
        end
      end
      BE_OUT: begin
        if (!ov_r || out_ready) begin
          res_nxt.linear_sector = s_r;
          res_nxt.byte_offset   = {s_r, 9'd0};
          res_nxt.status        = ovf_r && geometry_mode;
          res_nxt.cylinder      = '0;
          res_nxt.head          = '0;
          res_nxt.sector_in_track = '0;
          if (geometry_mode && !ovf_r) begin
            sec_sum = 10'(rem_r) + 10'd1 + {2'd0, sector_bias};
            res_nxt.cylinder        = cyl_r;
            res_nxt.head            = quo_r[7:0];
            res_nxt.sector_in_track = sec_sum[8:0];
          end
          ov_nxt = 1'b1;
          st_nxt = BE_IDLE;
        end
      end
      default: st_nxt = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BE_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt; s_r <= s_nxt; i_r <= i_nxt; first_r <= first_nxt;
    quo_r <= quo_nxt; rem_r <= rem_nxt; bit_r <= bit_nxt; cyl_r <= cyl_nxt;
    ovf_r <= ovf_nxt; res_r <= res_nxt;
  end
endmodule

@@ hdl/block_to_disk_sector_translator.sv @@
// path of a translate from the accepting edge to out valid: queue, multiply, walk of
// bad_count table entries (capped at table depth) on the ram read port, partition
// offset, in geometry mode and in range two bit-serial divides, output register;
// two-entry queue in front; loads wait while a translate is queued or walking the table
// throughput: one translate at a time in the back end
// reset: synchronous active-low rst_n restores register defaults; table is not cleared
module block_to_disk_sector_translator import bdst_pkg::*; #(
  parameter int unsigned MAX_BAD_BLOCKS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  bdst_in_if.sink           in_ch,
  bdst_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);
  localparam int unsigned IW = $clog2(MAX_BAD_BLOCKS);

  // configuration registers
  logic [23:0] bpl_r;
  logic [31:0] pstart_r, last_r;
  logic [5:0]  ts_r;
  logic [13:0] cs_r;
  logic [7:0]  bias_r;
  logic        geo_r;
  logic [8:0]  bcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpl_r <= 24'd65535; pstart_r <= '0; last_r <= '1; ts_r <= 6'd9;
      cs_r <= 14'd18; bias_r <= '0; geo_r <= 1'b0; bcnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BLOCKS_PER_DISK:     bpl_r    <= cfg_data[23:0];
        REG_PARTITION_START:     pstart_r <= cfg_data;
        REG_LAST_ALLOWED_SECTOR: last_r   <= cfg_data;
        REG_TRACK_SECTORS:       ts_r     <= cfg_data[5:0];
        REG_CYLINDER_SECTORS:    cs_r     <= cfg_data[13:0];
        REG_SECTOR_BIAS:         bias_r   <= cfg_data[7:0];
        REG_GEOMETRY_MODE:       geo_r    <= cfg_data[0];
        REG_BAD_COUNT:           bcnt_r   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic          tbl_we;
  logic [IW-1:0] tbl_waddr, tbl_raddr;
  logic [31:0]   tbl_wdata, tbl_rdata;
  logic          q_valid, q_pop, tbl_busy;
  xlate_req_t    q_data;

  // front: intake and table writes
  bdst_front #(.MAX_BAD_BLOCKS(MAX_BAD_BLOCKS)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .tbl_we, .tbl_waddr, .tbl_wdata,
    .q_valid, .q_data, .q_pop, .tbl_busy
  );

  // bad-block table
  bdst_ram #(.WIDTH(32), .DEPTH(MAX_BAD_BLOCKS)) u_tbl (
    .clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  // back: translate engine
  bdst_back #(.MAX_BAD_BLOCKS(MAX_BAD_BLOCKS)) u_back (
    .clk, .rst_n,
    .q_valid, .q_data, .q_pop, .tbl_busy,
    .tbl_raddr, .tbl_rdata,
    .blocks_per_disk(bpl_r), .partition_start(pstart_r),
    .last_allowed_sector(last_r), .track_sectors(ts_r),
    .cylinder_sectors(cs_r), .sector_bias(bias_r),
    .geometry_mode(geo_r), .bad_count(bcnt_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule

@@ tb/block_to_disk_sector_translator_tb.sv @@
`timescale 1ns / 100ps

module block_to_disk_sector_translator_tb;
  import bdst_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  // slowest translate: full table walk plus both divisions, with margin
  localparam int unsigned DRAIN_CYCLES = 400;
  // cycles with no beat on either channel before giving up
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned ITEMS_PER_PHASE = 36;
  localparam int unsigned NUM_PHASES = 8;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_data;

  bdst_in_if  in_ch ();
  bdst_out_if out_ch ();

  block_to_disk_sector_translator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock, 20 ns period
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // shadow copy of the block's registers and bad-block table
  logic [23:0] m_blocks_per_disk;
  logic [31:0] m_partition_start;
  logic [31:0] m_last_allowed;
  logic [5:0]  m_track_sectors;
  logic [13:0] m_cylinder_sectors;
  logic [7:0]  m_sector_bias;
  logic        m_geometry;
  logic [8:0]  m_bad_count;
  logic [31:0] m_bad_table [TABLE_DEPTH];

  out_item_t   expected_sectors [$];
  int unsigned fault_count;
  int unsigned quiet_cycles;
  bit          idle_on;   // random gaps on both channels
  bit          hold_req;  // ask the receiver for one long hold-off

  // one directed row: typed expectation only where it is obvious
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  function automatic void apply_cfg(cfg_reg_t r, logic [31:0] v);
    case (r)
      REG_BLOCKS_PER_DISK:     m_blocks_per_disk = v[23:0];
      REG_PARTITION_START:     m_partition_start = v;
      REG_LAST_ALLOWED_SECTOR: m_last_allowed = v;
      REG_TRACK_SECTORS:       m_track_sectors = v[5:0];
      REG_CYLINDER_SECTORS:    m_cylinder_sectors = v[13:0];
      REG_SECTOR_BIAS:         m_sector_bias = v[7:0];
      REG_GEOMETRY_MODE:       m_geometry = v[0];
      REG_BAD_COUNT:           m_bad_count = v[8:0];
      default: ;
    endcase
  endfunction

  // sector translation as the block should compute it
  function automatic out_item_t translate_sector(in_item_t it);
    out_item_t   r;
    logic [31:0] s;
    logic [31:0] cs;
    logic [31:0] ts;
    logic [31:0] cyl;
    logic [31:0] rem;
    logic [31:0] hd;
    logic [31:0] sec;
    int unsigned n;
    r = '0;
    s = 32'(it.logical_disk) * 32'(m_blocks_per_disk) + 32'(it.record_number);
    n = (32'(m_bad_count) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(m_bad_count);
    for (int unsigned i = 0; i < n; i++) begin
      if (s >= m_bad_table[i]) s = s + 32'd1;
    end
    s = s + m_partition_start;
    if (m_geometry) begin
      if (s > m_last_allowed) begin
        r.status = 1'b1;
      end else begin
        // zero divisor counts as one
        cs = (m_cylinder_sectors == 0) ? 32'd1 : 32'(m_cylinder_sectors);
        ts = (m_track_sectors == 0) ? 32'd1 : 32'(m_track_sectors);
        cyl = s / cs;
        rem = s - cyl * cs;
        hd = rem / ts;
        sec = rem - hd * ts;
        r.cylinder = cyl;
        r.head = hd[7:0];  // head overflow wraps
        r.sector_in_track = 9'(sec + 32'd1 + 32'(m_sector_bias));
      end
    end
    r.linear_sector = s;
    r.byte_offset = 41'(s) << 9;
    return r;
  endfunction

  // register write, caller sits on a rising edge
  task automatic cfg_write(cfg_reg_t r, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    apply_cfg(r, v);
  endtask

  // offer one beat and wait for it to be taken
  task automatic send_beat(in_item_t it, bit typed, out_item_t want);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    if (it.command == CMD_LOAD) begin
      m_bad_table[it.table_index] = it.table_value;
    end else begin
      expected_sectors.push_back(typed ? want : translate_sector(it));
    end
    if (idle_on && $urandom_range(0, 99) < 12) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // stop driving, let every expected result come out, then idle before going on
  task automatic drain();
    in_ch.valid <= 1'b0;
    cfg_we <= 1'b0;
    @(posedge clk);
    while (expected_sectors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_table_value();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(0, 70000);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t pick_item();
    in_item_t it;
    it.command = ($urandom_range(0, 99) < 80) ? CMD_TRANSLATE : CMD_LOAD;
    case ($urandom_range(0, 9))
      0:       it.logical_disk = 8'd0;
      1:       it.logical_disk = 8'hFF;
      2, 3:    it.logical_disk = 8'($urandom_range(0, 3));
      default: it.logical_disk = 8'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       it.record_number = 16'd0;
      1:       it.record_number = 16'hFFFF;
      default: it.record_number = 16'($urandom);
    endcase
    it.table_index = 8'($urandom);
    it.table_value = pick_table_value();
    return it;
  endfunction

  // result checking, sampled mid-cycle where the handshake is settled
  always @(negedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_sectors.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = expected_sectors.pop_front();
        if (got.linear_sector !== want.linear_sector ||
            got.byte_offset !== want.byte_offset ||
            got.cylinder !== want.cylinder ||
            got.head !== want.head ||
            got.sector_in_track !== want.sector_in_track ||
            got.status !== want.status) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("mismatch: expected %p", want);
            $display("          actual   %p", got);
          end
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= rst_n && (!idle_on || $urandom_range(0, 99) >= 12);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  stim_row_t directed [$];

  initial begin
    out_item_t none;
    out_item_t top_sector;
    in_item_t  it;
    none = '0;
    top_sector = '0;
    // largest address at reset settings: 255*65535+65535
    top_sector.linear_sector = 32'd16776960;
    top_sector.byte_offset = 41'd8589803520;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    fault_count = 0;
    quiet_cycles = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;

    // register defaults after reset
    m_blocks_per_disk = 24'd65535;
    m_partition_start = 32'd0;
    m_last_allowed = 32'hFFFF_FFFF;
    m_track_sectors = 6'd9;
    m_cylinder_sectors = 14'd18;
    m_sector_bias = 8'd0;
    m_geometry = 1'b0;
    m_bad_count = 9'd0;
    foreach (m_bad_table[i]) m_bad_table[i] = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset settings, no table walk yet
    directed = '{
      '{'{CMD_TRANSLATE, 8'd0, 16'd0, 8'd0, 32'd0}, 1'b1, none},
      '{'{CMD_TRANSLATE, 8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF}, 1'b1, top_sector},
      '{'{CMD_LOAD, 8'd0, 16'd0, 8'd0, 32'hFFFF_FFFF}, 1'b0, none},
      '{'{CMD_LOAD, 8'hFF, 16'hFFFF, 8'hFF, 32'd0}, 1'b0, none},
      '{'{CMD_LOAD, 8'd0, 16'd0, 8'd0, 32'd100}, 1'b0, none},
      '{'{CMD_TRANSLATE, 8'd1, 16'd0, 8'd0, 32'd0}, 1'b0, none},
      '{'{CMD_TRANSLATE, 8'd0, 16'hFFFF, 8'd0, 32'd0}, 1'b0, none},
      '{'{CMD_TRANSLATE, 8'h80, 16'h8000, 8'h55, 32'hAAAA_5555}, 1'b0, none},
      '{'{CMD_TRANSLATE, 8'h7F, 16'h7FFF, 8'hAA, 32'h5555_AAAA}, 1'b0, none}
    };
    foreach (directed[i]) send_beat(directed[i].item, directed[i].typed, directed[i].want);

    // fill the whole table so no walk ever reads an unwritten entry
    drain();
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      it = pick_item();
      it.command = CMD_LOAD;
      it.table_index = i[7:0];
      it.table_value = pick_table_value();
      send_beat(it, 1'b0, none);
    end

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        0: begin  // smallest settings
          cfg_write(REG_BLOCKS_PER_DISK, 32'd1);
          cfg_write(REG_PARTITION_START, 32'd0);
          cfg_write(REG_LAST_ALLOWED_SECTOR, 32'hFFFF_FFFF);
          cfg_write(REG_TRACK_SECTORS, 32'd1);
          cfg_write(REG_CYLINDER_SECTORS, 32'd1);
          cfg_write(REG_SECTOR_BIAS, 32'd0);
          cfg_write(REG_GEOMETRY_MODE, 32'd1);
          cfg_write(REG_BAD_COUNT, 32'd0);
        end
        1: begin  // largest settings, partition start wraps the sum
          cfg_write(REG_BLOCKS_PER_DISK, 32'h00FF_FFFF);
          cfg_write(REG_PARTITION_START, 32'hFFFF_FFFF);
          cfg_write(REG_LAST_ALLOWED_SECTOR, 32'hFFFF_FFFF);
          cfg_write(REG_TRACK_SECTORS, 32'd63);
          cfg_write(REG_CYLINDER_SECTORS, 32'd16128);
          cfg_write(REG_SECTOR_BIAS, 32'd255);
          cfg_write(REG_BAD_COUNT, 32'd256);
        end
        2: begin  // zero divisors, count above the table saturates
          cfg_write(REG_BLOCKS_PER_DISK, 32'd65535);
          cfg_write(REG_PARTITION_START, 32'd1000);
          cfg_write(REG_LAST_ALLOWED_SECTOR, 32'h0080_0000);
          cfg_write(REG_TRACK_SECTORS, 32'd0);
          cfg_write(REG_CYLINDER_SECTORS, 32'd0);
          cfg_write(REG_SECTOR_BIAS, 32'd7);
          cfg_write(REG_BAD_COUNT, 32'd511);
        end
        3: begin  // linear mode, no idling on either side
          cfg_write(REG_BLOCKS_PER_DISK, 32'd300);
          cfg_write(REG_PARTITION_START, 32'd12345);
          cfg_write(REG_GEOMETRY_MODE, 32'd0);
          cfg_write(REG_BAD_COUNT, 32'd32);
          idle_on = 1'b0;
        end
        4: begin  // one sector per track so head overflows, most sectors out of range
          cfg_write(REG_BLOCKS_PER_DISK, 32'd70);
          cfg_write(REG_PARTITION_START, 32'd0);
          cfg_write(REG_LAST_ALLOWED_SECTOR, 32'd0);
          cfg_write(REG_TRACK_SECTORS, 32'd1);
          cfg_write(REG_CYLINDER_SECTORS, 32'd16128);
          cfg_write(REG_GEOMETRY_MODE, 32'd1);
          cfg_write(REG_BAD_COUNT, 32'd16);
          cfg_write(REG_LAST_ALLOWED_SECTOR, 32'h0000_8000);
          idle_on = 1'b1;
          hold_req = 1'b1;  // output held off while items keep coming
        end
        default: begin  // random settings, data bits above the width for sector bias and geometry mode
          cfg_write(REG_BLOCKS_PER_DISK, $urandom_range(1, 32'h00FF_FFFF));
          cfg_write(REG_PARTITION_START, $urandom);
          cfg_write(REG_LAST_ALLOWED_SECTOR, $urandom);
          cfg_write(REG_TRACK_SECTORS, $urandom_range(1, 63));
          cfg_write(REG_CYLINDER_SECTORS, $urandom_range(1, 16128));
          cfg_write(REG_SECTOR_BIAS, $urandom);
          cfg_write(REG_GEOMETRY_MODE, $urandom);
          cfg_write(REG_BAD_COUNT, $urandom_range(0, 300));
        end
      endcase
      cfg_we <= 1'b0;
      for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++) send_beat(pick_item(), 1'b0, none);
    end

    drain();
    if (fault_count == 0 && expected_sectors.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
